@@ rtl/dd_pkg.sv @@
// Shared types and constants for the deadlock detector.
package dd_pkg;

    localparam int DATA_W     = 8;
    localparam int WORK_W     = 13;
    localparam int PIDX_W     = 4;
    localparam int RIDX_W     = 3;
    localparam int NP_CFG_W   = 5;
    localparam int NR_CFG_W   = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WORK_W-1:0] WORK_MAX = 13'd8191;

    localparam logic [NP_CFG_W-1:0] NUM_PROC_RST = 5'd16;
    localparam logic [NR_CFG_W-1:0] NUM_RES_RST  = 4'd8;

    typedef enum logic [1:0] {
        CMD_LOAD_MATRIX = 2'd0,
        CMD_LOAD_AVAIL  = 2'd1,
        CMD_DETECT      = 2'd2,
        CMD_NOP         = 2'd3
    } cmd_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_PROC = 1'b0,
        CFG_NUM_RES  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        WOP_NONE = 2'd0,
        WOP_COPY = 2'd1,
        WOP_ADD  = 2'd2
    } work_op_t;

    typedef struct packed {
        logic     avail_we;
        work_op_t op;
    } work_ctrl_t;

endpackage

@@ rtl/dd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dd_work.sv @@
// Available and work vectors with the shared compare and saturating-add unit.
module dd_work #(
    parameter int MAX_RES = 8
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  dd_pkg::work_ctrl_t                         ctrl,
    input  logic [(MAX_RES > 1 ? $clog2(MAX_RES) : 1)-1:0] idx,
    input  logic [dd_pkg::DATA_W-1:0]                  avail_wdata,
    input  logic [dd_pkg::DATA_W-1:0]                  alloc,
    input  logic [dd_pkg::DATA_W-1:0]                  request,
    output logic                                       fits
);
    import dd_pkg::*;

    logic [DATA_W-1:0] avail_reg [MAX_RES];
    logic [WORK_W-1:0] work_reg  [MAX_RES];
    logic [WORK_W:0]   sum;
    logic [WORK_W-1:0] sat_sum;

    assign fits    = WORK_W'(request) <= work_reg[idx];
    assign sum     = (WORK_W + 1)'(work_reg[idx]) + (WORK_W + 1)'(alloc);
    assign sat_sum = sum[WORK_W] ? WORK_MAX : sum[WORK_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.avail_we) begin
            avail_reg[idx] <= avail_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_RES; i++) begin
                work_reg[i] <= '0;
            end
        end else begin
            unique case (ctrl.op)
                WOP_COPY: work_reg[idx] <= WORK_W'(avail_reg[idx]);
                WOP_ADD:  work_reg[idx] <= sat_sum;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/deadlock_detection.sv @@
// Deadlock detector top level: load path, detection sequencer and result register.
//
// Matrix and available loads are written when accepted, one per clock while s_ready is
// high. A detect command holds s_ready low while a sequencer walks the allocation/request
// RAM through its single registered read port, a read and an evaluate state per entry:
// a zero-allocation scan over all NP*NR entries marks unallocated processes finished;
// each pass checks every process, compares each unfinished one's requests with work and,
// if all fit, adds its allocation; passes repeat until one finishes nothing. NP results
// follow, one per cycle while m_ready is high, from an output register.
module deadlock_detection #(
    parameter int MAX_PROC = 16,
    parameter int MAX_RES  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [dd_pkg::PIDX_W-1:0]       s_process_index,
    input  logic [dd_pkg::RIDX_W-1:0]       s_resource_index,
    input  logic [dd_pkg::DATA_W-1:0]       s_alloc_value,
    input  logic [dd_pkg::DATA_W-1:0]       s_request_value,
    input  logic [dd_pkg::DATA_W-1:0]       s_available_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dd_pkg::PIDX_W-1:0]       m_proc_id,
    output logic                            m_deadlocked,
    output logic                            m_any_deadlock,
    output logic                            m_last
);
    import dd_pkg::*;

    localparam int PW    = $clog2(MAX_PROC);
    localparam int PCW   = $clog2(MAX_PROC + 1);
    localparam int RW    = MAX_RES > 1 ? $clog2(MAX_RES) : 1;
    localparam int RCW   = $clog2(MAX_RES + 1);
    localparam int DEPTH = MAX_PROC * MAX_RES;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_RD,
        S_INIT_EV,
        S_SCAN_CHK,
        S_CMP_RD,
        S_CMP_EV,
        S_ADD_RD,
        S_ADD_EV,
        S_NEXT,
        S_OUT
    } state_t;

    state_t                state_reg;
    logic [NP_CFG_W-1:0]   num_proc_reg;
    logic [NR_CFG_W-1:0]   num_res_reg;
    logic [PCW-1:0]        np_reg;
    logic [RCW-1:0]        nr_reg;
    logic [PCW-1:0]        p_reg;
    logic [RCW-1:0]        r_reg;
    logic [MAX_PROC-1:0]   finished_reg;
    logic                  zero_reg;
    logic                  fits_reg;
    logic                  progress_reg;
    logic                  any_reg;
    logic                  m_valid_reg;
    logic [PIDX_W-1:0]     m_proc_id_reg;
    logic                  m_deadlocked_reg;
    logic                  m_any_reg;
    logic                  m_last_reg;

    logic                  s_xfer;
    logic                  proc_ok;
    logic                  res_ok;
    logic                  mat_we;
    logic [AW-1:0]         mat_waddr;
    logic [AW-1:0]         mat_raddr;
    logic [2*DATA_W-1:0]   mat_rdata;
    logic [DATA_W-1:0]     rd_alloc;
    logic [DATA_W-1:0]     rd_request;
    logic [RW-1:0]         w_idx;
    work_ctrl_t            w_ctrl;
    logic                  w_fits;
    logic                  r_last;
    logic                  p_last;
    logic [PCW-1:0]        p_inc;
    logic [RCW-1:0]        r_inc;
    logic [PCW-1:0]        np_clamp;
    logic [RCW-1:0]        nr_clamp;
    logic                  zero_n;
    logic                  fits_n;

    assign s_ready   = state_reg == S_IDLE;
    assign s_xfer    = s_valid && s_ready;
    assign proc_ok   = 32'(s_process_index) < MAX_PROC;
    assign res_ok    = 32'(s_resource_index) < MAX_RES;
    assign mat_we    = s_xfer && s_cmd == CMD_LOAD_MATRIX && proc_ok && res_ok;
    assign mat_waddr = AW'(32'(s_process_index) * MAX_RES + 32'(s_resource_index));
    assign mat_raddr = AW'(32'(p_reg[PW-1:0]) * MAX_RES + 32'(r_reg[RW-1:0]));
    assign rd_alloc   = mat_rdata[2*DATA_W-1:DATA_W];
    assign rd_request = mat_rdata[DATA_W-1:0];

    assign p_inc  = p_reg + 1'b1;
    assign r_inc  = r_reg + 1'b1;
    assign p_last = p_inc == np_reg;
    assign r_last = r_inc == nr_reg;
    assign zero_n = zero_reg && rd_alloc == '0;
    assign fits_n = fits_reg && w_fits;

    assign np_clamp = num_proc_reg == '0 ? PCW'(1) :
                      32'(num_proc_reg) > MAX_PROC ? PCW'(MAX_PROC) : PCW'(num_proc_reg);
    assign nr_clamp = num_res_reg == '0 ? RCW'(1) :
                      32'(num_res_reg) > MAX_RES ? RCW'(MAX_RES) : RCW'(num_res_reg);

    assign w_idx = state_reg == S_IDLE ? RW'(s_resource_index) : r_reg[RW-1:0];

    always_comb begin
        w_ctrl.avail_we = s_xfer && s_cmd == CMD_LOAD_AVAIL && res_ok;
        if (state_reg == S_INIT_EV && p_reg == '0) begin
            w_ctrl.op = WOP_COPY;
        end else if (state_reg == S_ADD_EV) begin
            w_ctrl.op = WOP_ADD;
        end else begin
            w_ctrl.op = WOP_NONE;
        end
    end

    dd_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (DEPTH)
    ) u_mat (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata ({s_alloc_value, s_request_value}),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    dd_work #(
        .MAX_RES (MAX_RES)
    ) u_work (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (w_ctrl),
        .idx         (w_idx),
        .avail_wdata (s_available_value),
        .alloc       (rd_alloc),
        .request     (rd_request),
        .fits        (w_fits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_proc_reg <= NUM_PROC_RST;
            num_res_reg  <= NUM_RES_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_PROC: num_proc_reg <= cfg_wdata[NP_CFG_W-1:0];
                CFG_NUM_RES:  num_res_reg  <= cfg_wdata[NR_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            np_reg       <= PCW'(1);
            nr_reg       <= RCW'(1);
            p_reg        <= '0;
            r_reg        <= '0;
            finished_reg <= '0;
            zero_reg     <= 1'b1;
            fits_reg     <= 1'b1;
            progress_reg <= 1'b0;
            any_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_xfer && s_cmd == CMD_DETECT) begin
                        np_reg    <= np_clamp;
                        nr_reg    <= nr_clamp;
                        p_reg     <= '0;
                        r_reg     <= '0;
                        zero_reg  <= 1'b1;
                        state_reg <= S_INIT_RD;
                    end
                end
                S_INIT_RD: state_reg <= S_INIT_EV;
                S_INIT_EV: begin
                    if (r_last) begin
                        finished_reg[p_reg[PW-1:0]] <= zero_n;
                        r_reg    <= '0;
                        zero_reg <= 1'b1;
                        if (p_last) begin
                            p_reg        <= '0;
                            progress_reg <= 1'b0;
                            any_reg      <= 1'b0;
                            state_reg    <= S_SCAN_CHK;
                        end else begin
                            p_reg     <= p_inc;
                            state_reg <= S_INIT_RD;
                        end
                    end else begin
                        zero_reg  <= zero_n;
                        r_reg     <= r_inc;
                        state_reg <= S_INIT_RD;
                    end
                end
                S_SCAN_CHK: begin
                    r_reg    <= '0;
                    fits_reg <= 1'b1;
                    if (finished_reg[p_reg[PW-1:0]]) begin
                        state_reg <= S_NEXT;
                    end else begin
                        state_reg <= S_CMP_RD;
                    end
                end
                S_CMP_RD: state_reg <= S_CMP_EV;
                S_CMP_EV: begin
                    if (r_last) begin
                        r_reg <= '0;
                        if (fits_n) begin
                            state_reg <= S_ADD_RD;
                        end else begin
                            any_reg   <= 1'b1;
                            state_reg <= S_NEXT;
                        end
                    end else begin
                        fits_reg  <= fits_n;
                        r_reg     <= r_inc;
                        state_reg <= S_CMP_RD;
                    end
                end
                S_ADD_RD: state_reg <= S_ADD_EV;
                S_ADD_EV: begin
                    if (r_last) begin
                        finished_reg[p_reg[PW-1:0]] <= 1'b1;
                        progress_reg <= 1'b1;
                        state_reg    <= S_NEXT;
                    end else begin
                        r_reg     <= r_inc;
                        state_reg <= S_ADD_RD;
                    end
                end
                S_NEXT: begin
                    if (!p_last) begin
                        p_reg     <= p_inc;
                        state_reg <= S_SCAN_CHK;
                    end else if (progress_reg) begin
                        p_reg        <= '0;
                        progress_reg <= 1'b0;
                        any_reg      <= 1'b0;
                        state_reg    <= S_SCAN_CHK;
                    end else begin
                        p_reg            <= '0;
                        m_valid_reg      <= 1'b1;
                        m_proc_id_reg    <= '0;
                        m_deadlocked_reg <= !finished_reg[0];
                        m_any_reg        <= any_reg;
                        m_last_reg       <= np_reg == PCW'(1);
                        state_reg        <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (m_last_reg) begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end else begin
                            p_reg            <= p_inc;
                            m_proc_id_reg    <= PIDX_W'(p_inc);
                            m_deadlocked_reg <= !finished_reg[p_inc[PW-1:0]];
                            m_last_reg       <= (p_inc + 1'b1) == np_reg;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_proc_id      = m_proc_id_reg;
    assign m_deadlocked   = m_deadlocked_reg;
    assign m_any_deadlock = m_any_reg;
    assign m_last         = m_last_reg;

endmodule

@@ bench/testbench.sv @@
// Deadlock detector testbench: directed script then random load/detect sequences vs. a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dd_pkg::*;

    localparam int NPROC         = 16;
    localparam int NRES          = 8;
    localparam int ITEM_TARGET   = 500;
    localparam int STALL_LIMIT   = 30000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int SCRIPT_LEN    = 23;

    typedef struct packed {
        logic [PIDX_W-1:0] proc_id;
        logic              deadlocked;
        logic              any_deadlock;
        logic              last;
    } report_t;

    typedef struct packed {
        logic known;
        logic dead_f;
        logic any_f;
    } preset_t;

    typedef enum logic {ROW_ITEM, ROW_COUNTS} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        cmd_e_t              cmd;
        logic [PIDX_W-1:0]   pidx;
        logic [RIDX_W-1:0]   ridx;
        logic [DATA_W-1:0]   av;
        logic [DATA_W-1:0]   rq;
        logic [DATA_W-1:0]   fv;
        logic [4:0]          np_val;
        logic [4:0]          nr_val;
        preset_t             pre;
    } row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    cfg_idx_t               cfg_index = CFG_NUM_PROC;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    cmd_e_t                 s_cmd = CMD_NOP;
    logic [PIDX_W-1:0]      s_process_index = '0;
    logic [RIDX_W-1:0]      s_resource_index = '0;
    logic [DATA_W-1:0]      s_alloc_value = '0;
    logic [DATA_W-1:0]      s_request_value = '0;
    logic [DATA_W-1:0]      s_available_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [PIDX_W-1:0]      m_proc_id;
    logic                   m_deadlocked;
    logic                   m_any_deadlock;
    logic                   m_last;

    // predictor state
    logic [DATA_W-1:0] tbl_alloc [NPROC][NRES];
    logic [DATA_W-1:0] tbl_req [NPROC][NRES];
    logic [DATA_W-1:0] vec_avail [NRES];
    logic [WORK_W-1:0] work_cnt [NRES];
    bit                done_flag [NPROC];
    logic [NP_CFG_W-1:0] np_cfg = NUM_PROC_RST;
    logic [NR_CFG_W-1:0] nr_cfg = NUM_RES_RST;

    report_t pending_reports[$];
    preset_t preset_q[$];

    // stimulus side bookkeeping
    bit alloc_set [NPROC][NRES];
    bit avail_set [NRES];
    int cur_np = NPROC;
    int cur_nr = NRES;
    int items_sent = 0;
    int reports_seen = 0;
    int errors = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    row_t script [SCRIPT_LEN];

    deadlock_detection u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_process_index   (s_process_index),
        .s_resource_index  (s_resource_index),
        .s_alloc_value     (s_alloc_value),
        .s_request_value   (s_request_value),
        .s_available_value (s_available_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_proc_id         (m_proc_id),
        .m_deadlocked      (m_deadlocked),
        .m_any_deadlock    (m_any_deadlock),
        .m_last            (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic int clamp_count(int v, int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic void find_deadlocks();
        int np_use;
        int nr_use;
        bit progress;
        bit fits;
        bit any_dead;
        logic [WORK_W:0] sum;
        report_t rep;
        np_use = clamp_count(int'(np_cfg), NPROC);
        nr_use = clamp_count(int'(nr_cfg), NRES);
        for (int p = 0; p < np_use; p++) begin
            done_flag[p] = 1'b1;
            for (int r = 0; r < nr_use; r++)
                if (tbl_alloc[p][r] != '0) done_flag[p] = 1'b0;
        end
        for (int r = 0; r < nr_use; r++)
            work_cnt[r] = WORK_W'(vec_avail[r]);
        do begin
            progress = 1'b0;
            for (int p = 0; p < np_use; p++) begin
                if (!done_flag[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < nr_use; r++)
                        if (WORK_W'(tbl_req[p][r]) > work_cnt[r]) fits = 1'b0;
                    if (fits) begin
                        for (int r = 0; r < nr_use; r++) begin
                            sum = {1'b0, work_cnt[r]} + (WORK_W + 1)'(tbl_alloc[p][r]);
                            work_cnt[r] = (sum > {1'b0, WORK_MAX}) ? WORK_MAX : sum[WORK_W-1:0];
                        end
                        done_flag[p] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end while (progress);
        any_dead = 1'b0;
        for (int p = 0; p < np_use; p++)
            if (!done_flag[p]) any_dead = 1'b1;
        for (int p = 0; p < np_use; p++) begin
            rep.proc_id      = PIDX_W'(p);
            rep.deadlocked   = !done_flag[p];
            rep.any_deadlock = any_dead;
            rep.last         = (p == np_use - 1);
            pending_reports.push_back(rep);
        end
    endfunction

    function automatic void apply_item(cmd_e_t cmd, logic [PIDX_W-1:0] pidx,
                                       logic [RIDX_W-1:0] ridx, logic [DATA_W-1:0] av,
                                       logic [DATA_W-1:0] rq, logic [DATA_W-1:0] fv);
        case (cmd)
            CMD_LOAD_MATRIX: begin
                tbl_alloc[pidx][ridx] = av;
                tbl_req[pidx][ridx]   = rq;
            end
            CMD_LOAD_AVAIL: begin
                vec_avail[ridx] = fv;
            end
            CMD_DETECT: begin
                find_deadlocks();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endfunction

    function automatic row_t item_row(cmd_e_t c, logic [PIDX_W-1:0] p, logic [RIDX_W-1:0] r,
                                      logic [DATA_W-1:0] a, logic [DATA_W-1:0] q,
                                      logic [DATA_W-1:0] v);
        row_t rw;
        rw        = '0;
        rw.kind   = ROW_ITEM;
        rw.cmd    = c;
        rw.pidx   = p;
        rw.ridx   = r;
        rw.av     = a;
        rw.rq     = q;
        rw.fv     = v;
        return rw;
    endfunction

    function automatic row_t counts_row(logic [4:0] npv, logic [4:0] nrv);
        row_t rw;
        rw        = '0;
        rw.kind   = ROW_COUNTS;
        rw.cmd    = CMD_NOP;
        rw.np_val = npv;
        rw.nr_val = nrv;
        return rw;
    endfunction

    function automatic row_t with_result(row_t rw, logic dead_f, logic any_f);
        row_t o;
        o     = rw;
        o.pre = '{1'b1, dead_f, any_f};
        return o;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(int style);
        case (style)
            0: return DATA_W'($urandom);
            1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return DATA_W'($urandom_range(0, 3));
        endcase
    endfunction

    // model update and result check share one block so queue order is fixed
    always @(posedge aclk) begin
        preset_t pre;
        report_t want;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NUM_PROC: np_cfg = cfg_wdata[NP_CFG_W-1:0];
                    CFG_NUM_RES:  nr_cfg = cfg_wdata[NR_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                pre = preset_q.pop_front();
                apply_item(s_cmd, s_process_index, s_resource_index, s_alloc_value,
                           s_request_value, s_available_value);
                if (pre.known) begin
                    void'(pending_reports.pop_back());
                    pending_reports.push_back('{PIDX_W'(0), pre.dead_f, pre.any_f, 1'b1});
                end
            end
            if (m_valid && m_ready) begin
                reports_seen <= reports_seen + 1;
                if (pending_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, expected none actual proc_id %0d",
                             $time, m_proc_id);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("proc_id", want.proc_id, m_proc_id);
                    check_field("deadlocked", want.deadlocked, m_deadlocked);
                    check_field("any_deadlock", want.any_deadlock, m_any_deadlock);
                    check_field("last", want.last, m_last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!hold_done && reports_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (reports_seen >= 150 && reports_seen < 300) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("deadlock_detection test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(cmd_e_t cmd, logic [PIDX_W-1:0] pidx, logic [RIDX_W-1:0] ridx,
                             logic [DATA_W-1:0] av, logic [DATA_W-1:0] rq,
                             logic [DATA_W-1:0] fv, preset_t pre);
        if (!(items_sent >= 200 && items_sent < 320) && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        preset_q.push_back(pre);
        s_valid           <= 1'b1;
        s_cmd             <= cmd;
        s_process_index   <= pidx;
        s_resource_index  <= ridx;
        s_alloc_value     <= av;
        s_request_value   <= rq;
        s_available_value <= fv;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_LOAD_MATRIX) alloc_set[pidx][ridx] = 1'b1;
        if (cmd == CMD_LOAD_AVAIL) avail_set[ridx] = 1'b1;
        if (cmd != CMD_NOP) items_sent++;
    endtask

    // drain outstanding reports and let any load finish before touching config
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_counts(logic [4:0] npv, logic [4:0] nrv);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_PROC;
        cfg_wdata <= npv;
        @(posedge aclk);
        cfg_index <= CFG_NUM_RES;
        cfg_wdata <= nrv;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_np = clamp_count(int'(npv), NPROC);
        cur_nr = clamp_count(int'(nrv[NR_CFG_W-1:0]), NRES);
    endtask

    initial begin
        int epoch;
        int reps;
        int style;
        logic [4:0] npw;
        logic [4:0] nrw;

        script = '{
            counts_row(5'd1, 5'd1),
            item_row(CMD_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0),
            item_row(CMD_LOAD_MATRIX, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0),
            with_result(item_row(CMD_DETECT, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0), 1'b0, 1'b0),
            item_row(CMD_LOAD_MATRIX, 4'd0, 3'd0, 8'd255, 8'd255, 8'd0),
            with_result(item_row(CMD_DETECT, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0), 1'b1, 1'b1),
            item_row(CMD_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd255),
            with_result(item_row(CMD_DETECT, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0), 1'b0, 1'b0),
            item_row(CMD_NOP, 4'd15, 3'd7, 8'd255, 8'd255, 8'd255),
            with_result(item_row(CMD_DETECT, 4'd15, 3'd7, 8'd255, 8'd255, 8'd255),
                        1'b0, 1'b0),
            counts_row(5'd0, 5'd0),
            item_row(CMD_LOAD_AVAIL, 4'd9, 3'd0, 8'hAA, 8'h55, 8'd254),
            with_result(item_row(CMD_DETECT, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0), 1'b1, 1'b1),
            counts_row(5'd2, 5'd2),
            item_row(CMD_LOAD_MATRIX, 4'd0, 3'd0, 8'd1, 8'd0, 8'd255),
            item_row(CMD_LOAD_MATRIX, 4'd0, 3'd1, 8'd0, 8'd1, 8'd0),
            item_row(CMD_LOAD_MATRIX, 4'd1, 3'd0, 8'd0, 8'd1, 8'd0),
            item_row(CMD_LOAD_MATRIX, 4'd1, 3'd1, 8'd1, 8'd0, 8'd0),
            item_row(CMD_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0),
            item_row(CMD_LOAD_AVAIL, 4'd0, 3'd1, 8'd0, 8'd0, 8'd0),
            item_row(CMD_DETECT, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0),
            item_row(CMD_LOAD_AVAIL, 4'd0, 3'd0, 8'd0, 8'd0, 8'd1),
            item_row(CMD_DETECT, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (script[i].kind == ROW_COUNTS)
                set_counts(script[i].np_val, script[i].nr_val);
            else
                send_item(script[i].cmd, script[i].pidx, script[i].ridx, script[i].av,
                          script[i].rq, script[i].fv, script[i].pre);
        end

        epoch = 0;
        while (items_sent < ITEM_TARGET) begin
            case (epoch)
                0: begin
                    npw = 5'd31;
                    nrw = 5'd31;
                end
                1: begin
                    npw = 5'd16;
                    nrw = 5'd8;
                end
                default: begin
                    if ($urandom_range(0, 9) < 7) begin
                        npw = 5'($urandom_range(1, 6));
                        nrw = 5'($urandom_range(1, 3));
                    end else begin
                        npw = 5'($urandom);
                        nrw = 5'($urandom);
                    end
                end
            endcase
            set_counts(npw, nrw);
            reps = $urandom_range(2, 5);
            for (int s = 0; s < reps && items_sent < ITEM_TARGET; s++) begin
                style = $urandom_range(0, 3);
                if (cur_np * cur_nr <= 12) begin
                    for (int p = 0; p < cur_np; p++)
                        for (int r = 0; r < cur_nr; r++)
                            send_item(CMD_LOAD_MATRIX, PIDX_W'(p), RIDX_W'(r),
                                      pick_value(style), pick_value(style),
                                      DATA_W'($urandom), '0);
                end else begin
                    repeat (10)
                        send_item(CMD_LOAD_MATRIX, PIDX_W'($urandom_range(0, cur_np - 1)),
                                  RIDX_W'($urandom_range(0, cur_nr - 1)),
                                  pick_value(style), pick_value(style),
                                  DATA_W'($urandom), '0);
                end
                for (int r = 0; r < cur_nr; r++)
                    if (cur_np * cur_nr <= 12 || $urandom_range(0, 1))
                        send_item(CMD_LOAD_AVAIL, PIDX_W'($urandom), RIDX_W'(r),
                                  DATA_W'($urandom), DATA_W'($urandom), pick_value(style), '0);
                if ($urandom_range(0, 9) == 0)
                    send_item(CMD_NOP, PIDX_W'($urandom), RIDX_W'($urandom), DATA_W'($urandom),
                              DATA_W'($urandom), DATA_W'($urandom), '0);
                if ($urandom_range(0, 9) == 0)
                    send_item(CMD_LOAD_MATRIX, PIDX_W'($urandom), RIDX_W'($urandom),
                              DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), '0);
                // every entry a detection will read must hold a value
                for (int p = 0; p < cur_np; p++)
                    for (int r = 0; r < cur_nr; r++)
                        if (!alloc_set[p][r])
                            send_item(CMD_LOAD_MATRIX, PIDX_W'(p), RIDX_W'(r),
                                      pick_value(style), pick_value(style),
                                      DATA_W'($urandom), '0);
                for (int r = 0; r < cur_nr; r++)
                    if (!avail_set[r])
                        send_item(CMD_LOAD_AVAIL, PIDX_W'($urandom), RIDX_W'(r),
                                  DATA_W'($urandom), DATA_W'($urandom), pick_value(style), '0);
                send_item(CMD_DETECT, PIDX_W'($urandom), RIDX_W'($urandom), DATA_W'($urandom),
                          DATA_W'($urandom), DATA_W'($urandom), '0);
                if ($urandom_range(0, 9) == 0)
                    send_item(CMD_DETECT, PIDX_W'($urandom), RIDX_W'($urandom),
                              DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), '0);
            end
            epoch++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_reports.size() == 0)
            $display("deadlock_detection test passed");
        else
            $display("deadlock_detection test failed");
        $finish;
    end

endmodule
